[design/ae_hit_detector_macros.svh]
// Assertion macros for the acoustic-emission hit detector.
// Included by the top level; expects clk and rst_n in scope at each use.
`ifndef AE_HIT_DETECTOR_MACROS_SVH
`define AE_HIT_DETECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define AE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define AE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ae_hd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the acoustic-emission hit detector.
// No dependencies; used by ae_hd_front, ae_hd_track and ae_hit_detector.
package ae_hd_pkg;

  // Sample index and mark width; all ones means minus one
  localparam int IDX_W = 25;
  localparam int TIME_W = 24;
  localparam int THR_W = 15;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W = 16;

  // Result field widths
  localparam int PRE_CNT_W = 11;
  localparam int BODY_CNT_W = 13;
  localparam int POST_CNT_W = 11;

  // Configuration register indexes
  localparam logic [2:0] REG_THR = 3'd0;
  localparam logic [2:0] REG_PDT = 3'd1;
  localparam logic [2:0] REG_HDT = 3'd2;
  localparam logic [2:0] REG_HLT = 3'd3;
  localparam logic [2:0] REG_MDT = 3'd4;

  typedef enum logic [1:0] {
    ROLE_PRE  = 2'd0,
    ROLE_BODY = 2'd1,
    ROLE_POST = 2'd2,
    ROLE_DROP = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    SEND_NONE  = 2'd0,
    SEND_POST  = 2'd1,
    SEND_TRUNC = 2'd2
  } send_t;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic [TIME_W-1:0] pdt;
    logic [TIME_W-1:0] hdt;
    logic [TIME_W-1:0] hlt;
    logic [TIME_W-1:0] mdt;
  } cfg_t;

  // Input stage contents handed to the hit tracker
  typedef struct packed {
    logic             valid;
    logic             active;
    logic [MAG_W-1:0] mag;
  } stage_t;

  typedef struct packed {
    role_t                 role;
    logic                  hit_start;
    send_t                 send_kind;
    logic [PRE_CNT_W-1:0]  pre_count;
    logic [BODY_CNT_W-1:0] body_count;
    logic [POST_CNT_W-1:0] post_count;
    logic [MAG_W-1:0]      peak_level;
  } result_t;

endpackage

[design/ae_hd_front.sv]
`timescale 1ns / 1ps
// Input register stage: takes a sample transaction, registers its magnitude
// and the threshold compare. Depends on ae_hd_pkg.
module ae_hd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ae_hd_pkg::SAMPLE_W-1:0] sample,
  input  logic [ae_hd_pkg::THR_W-1:0]    thr,
  input  logic                           take,
  output ae_hd_pkg::stage_t              stage
);

  logic                        valid_r;
  logic                        active_r;
  logic [ae_hd_pkg::MAG_W-1:0] mag_r;
  logic [ae_hd_pkg::MAG_W-1:0] mag_nxt;
  logic [ae_hd_pkg::THR_W-1:0] thr_eff;

  // Accept whenever the stage is empty or drains this cycle
  assign in_tready = !valid_r || take;

  // Two's complement magnitude; the most negative sample maps to 32768
  assign mag_nxt = sample[ae_hd_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  // A zero threshold behaves as one
  assign thr_eff = (thr == '0) ? ae_hd_pkg::THR_W'(1) : thr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Hold the payload of the accepted transaction
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mag_r    <= mag_nxt;
      active_r <= (mag_nxt >= {1'b0, thr_eff});
    end
  end

  assign stage.valid  = valid_r;
  assign stage.active = active_r;
  assign stage.mag    = mag_r;

endmodule

[design/ae_hd_track.sv]
`timescale 1ns / 1ps
// Hit state: peak, quiet, lockout and duration marks, pre/body/post counts,
// and the per-sample decision that builds one result. Depends on ae_hd_pkg.
module ae_hd_track #(
  parameter int PRE_DEPTH  = 1024,
  parameter int BODY_DEPTH = 4096,
  parameter int POST_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ae_hd_pkg::cfg_t      cfg,
  input  ae_hd_pkg::stage_t    stage,
  input  logic                 step,
  output ae_hd_pkg::result_t   res
);

  localparam int IW     = ae_hd_pkg::IDX_W;
  localparam int PRE_W  = $clog2(PRE_DEPTH + 1);
  localparam int BODY_W = $clog2(BODY_DEPTH + 1);
  localparam int POST_W = $clog2(POST_DEPTH + 1);
  localparam logic [IW-1:0]     IDX_ALL  = '1;
  localparam logic [PRE_W-1:0]  PRE_MAX  = PRE_W'(PRE_DEPTH);
  localparam logic [BODY_W-1:0] BODY_MAX = BODY_W'(BODY_DEPTH);
  localparam logic [POST_W-1:0] POST_MAX = POST_W'(POST_DEPTH);

  logic [IW-1:0]                idx_r, idx_nxt;
  logic [ae_hd_pkg::MAG_W-1:0]  peak_r, peak_nxt;
  logic [IW-1:0]                pk_mark_r, pk_mark_nxt;
  logic [IW-1:0]                q_mark_r, q_mark_nxt;
  logic [IW-1:0]                lo_mark_r, lo_mark_nxt;
  logic                         pk_ok_r, pk_ok_nxt;
  logic                         q_ok_r, q_ok_nxt;
  logic                         lo_ok_r, lo_ok_nxt;
  logic                         smv_r, smv_nxt;
  logic                         sent_r, sent_nxt;
  logic [PRE_W-1:0]             hist_r, hist_nxt;
  logic [BODY_W-1:0]            bf_r, bf_nxt;
  logic [POST_W-1:0]            pf_r, pf_nxt;

  ae_hd_pkg::role_t             role_v;
  ae_hd_pkg::send_t             kind_v;
  logic                         start_v;
  logic [PRE_W-1:0]             pre_v;
  logic [BODY_W-1:0]            body_v;
  logic [POST_W-1:0]            post_v;

  always_comb begin
    logic          fin;
    logic          rearm;
    logic [IW-1:0] d_pk;
    logic [IW-1:0] d_q;
    logic [IW-1:0] d_lo;

    idx_nxt     = idx_r;
    peak_nxt    = peak_r;
    pk_mark_nxt = pk_mark_r;
    q_mark_nxt  = q_mark_r;
    lo_mark_nxt = lo_mark_r;
    pk_ok_nxt   = pk_ok_r;
    q_ok_nxt    = q_ok_r;
    lo_ok_nxt   = lo_ok_r;
    smv_nxt     = smv_r;
    sent_nxt    = sent_r;
    hist_nxt    = hist_r;
    bf_nxt      = bf_r;
    pf_nxt      = pf_r;
    role_v      = ae_hd_pkg::ROLE_DROP;
    kind_v      = ae_hd_pkg::SEND_NONE;
    start_v     = 1'b0;
    pre_v       = '0;
    body_v      = '0;
    post_v      = '0;
    fin         = 1'b0;
    rearm       = 1'b0;
    d_pk        = '0;
    d_q         = '0;
    d_lo        = '0;

    // Advance the sample index while a hit is open, saturating
    if (peak_nxt != '0 && idx_nxt != IDX_ALL) begin
      idx_nxt = idx_nxt + 1'b1;
    end

    // Start a hit and track its peak, or open a quiet run
    if (stage.active) begin
      if (peak_nxt == '0) begin
        idx_nxt = '0;
        smv_nxt = 1'b1;
        start_v = 1'b1;
        pre_v   = hist_nxt;
      end
      if (stage.mag > peak_nxt) begin
        peak_nxt    = stage.mag;
        pk_mark_nxt = idx_nxt;
        pk_ok_nxt   = 1'b1;
        q_ok_nxt    = 1'b0;
      end
    end else if (!q_ok_nxt) begin
      q_mark_nxt = idx_nxt;
      q_ok_nxt   = 1'b1;
    end

    if (pk_ok_nxt) begin
      d_pk = idx_nxt - pk_mark_nxt;
      if (d_pk >= {1'b0, cfg.pdt}) begin
        d_q = idx_nxt - q_mark_nxt;
        if (!q_ok_nxt) begin
          q_mark_nxt = idx_nxt;
          q_ok_nxt   = 1'b1;
        end else if (d_q >= {1'b0, cfg.hdt}) begin
          // Hit has ended: lockout, then post collection or send
          fin  = 1'b1;
          d_lo = idx_nxt - lo_mark_nxt;
          if (!lo_ok_nxt) begin
            lo_mark_nxt = idx_nxt;
            lo_ok_nxt   = 1'b1;
          end else if (d_lo >= {1'b0, cfg.hlt}) begin
            rearm = 1'b1;
          end
          if (!rearm && !sent_nxt) begin
            if (pf_nxt >= POST_MAX) begin
              if ((hist_nxt | PRE_W'(0)) != '0 || bf_nxt != '0 || pf_nxt != '0) begin
                kind_v   = ae_hd_pkg::SEND_POST;
                pre_v    = hist_nxt;
                body_v   = bf_nxt;
                post_v   = pf_nxt;
                sent_nxt = 1'b1;
                hist_nxt = '0;
                bf_nxt   = '0;
                pf_nxt   = '0;
              end
            end else begin
              pf_nxt = pf_nxt + 1'b1;
              role_v = ae_hd_pkg::ROLE_POST;
            end
          end
        end else if (stage.active) begin
          q_ok_nxt = 1'b0;
        end

        // Truncate at maximum duration
        if (!fin && smv_nxt && idx_nxt >= {1'b0, cfg.mdt}) begin
          fin  = 1'b1;
          d_lo = idx_nxt - lo_mark_nxt;
          if (!lo_ok_nxt) begin
            lo_mark_nxt = idx_nxt;
            lo_ok_nxt   = 1'b1;
          end else if (d_lo >= {1'b0, cfg.hlt}) begin
            rearm = 1'b1;
          end
          if (!rearm && !sent_nxt && (hist_nxt != '0 || bf_nxt != '0)) begin
            kind_v   = ae_hd_pkg::SEND_TRUNC;
            pre_v    = hist_nxt;
            body_v   = bf_nxt;
            post_v   = '0;
            sent_nxt = 1'b1;
            hist_nxt = '0;
            bf_nxt   = '0;
            pf_nxt   = '0;
          end
        end
      end

      if (!fin && bf_nxt < BODY_MAX) begin
        bf_nxt = bf_nxt + 1'b1;
        role_v = ae_hd_pkg::ROLE_BODY;
      end
    end

    // Rearm: drop all hit state
    if (rearm) begin
      idx_nxt     = IDX_ALL;
      peak_nxt    = '0;
      sent_nxt    = 1'b0;
      pk_mark_nxt = IDX_ALL;
      q_mark_nxt  = IDX_ALL;
      lo_mark_nxt = IDX_ALL;
      pk_ok_nxt   = 1'b0;
      q_ok_nxt    = 1'b0;
      lo_ok_nxt   = 1'b0;
      smv_nxt     = 1'b0;
      hist_nxt    = '0;
      bf_nxt      = '0;
      pf_nxt      = '0;
    end

    // Idle sample becomes pre-trigger history
    if (peak_nxt == '0 && !rearm) begin
      role_v = ae_hd_pkg::ROLE_PRE;
      if (hist_nxt < PRE_MAX) begin
        hist_nxt = hist_nxt + 1'b1;
      end
    end
  end

  // Advance hit state once per sample handed to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= IDX_ALL;
      peak_r    <= '0;
      pk_mark_r <= IDX_ALL;
      q_mark_r  <= IDX_ALL;
      lo_mark_r <= IDX_ALL;
      pk_ok_r   <= 1'b0;
      q_ok_r    <= 1'b0;
      lo_ok_r   <= 1'b0;
      smv_r     <= 1'b0;
      sent_r    <= 1'b0;
      hist_r    <= '0;
      bf_r      <= '0;
      pf_r      <= '0;
    end else if (step) begin
      idx_r     <= idx_nxt;
      peak_r    <= peak_nxt;
      pk_mark_r <= pk_mark_nxt;
      q_mark_r  <= q_mark_nxt;
      lo_mark_r <= lo_mark_nxt;
      pk_ok_r   <= pk_ok_nxt;
      q_ok_r    <= q_ok_nxt;
      lo_ok_r   <= lo_ok_nxt;
      smv_r     <= smv_nxt;
      sent_r    <= sent_nxt;
      hist_r    <= hist_nxt;
      bf_r      <= bf_nxt;
      pf_r      <= pf_nxt;
    end
  end

  assign res.role       = role_v;
  assign res.hit_start  = start_v;
  assign res.send_kind  = kind_v;
  assign res.pre_count  = ae_hd_pkg::PRE_CNT_W'(pre_v);
  assign res.body_count = ae_hd_pkg::BODY_CNT_W'(body_v);
  assign res.post_count = ae_hd_pkg::POST_CNT_W'(post_v);
  assign res.peak_level = peak_nxt;

endmodule

[design/ae_hit_detector.sv]
`timescale 1ns / 1ps
// Acoustic-emission hit detector: stream ports, configuration registers,
// result register and checks. Depends on ae_hd_pkg, ae_hd_front, ae_hd_track.
//
// Usage:
//   in_*  : one signed 16-bit sample per transaction (in_tdata[15:0]).
//   out_* : one result per sample. out_tuser carries role, hit_start and
//           send_kind; out_tdata carries pre/body/post counts and peak level.
//   cfg_* : write-only registers (threshold, peak definition, hit definition,
//           lockout and maximum duration times in samples); write only while
//           no sample is in flight.
// Path: a sample accepted into the input register has its result registered
//   in the result register and presented in out_tdata/out_tuser.
// Throughput: one sample per cycle while out_tready is high; the combinational
//   hit state update between the input and result registers sets this figure.
// Reset: registers return to their defaults, the detector is idle with empty
//   history, and both stages are empty.
// Stall: while out_tready is low the result holds; a sample is still taken
//   only into an empty input register; in_tready drops until the result goes.
module ae_hit_detector #(
  parameter int PRE_DEPTH  = 1024,
  parameter int BODY_DEPTH = 4096,
  parameter int POST_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [10:0] pre_count, [23:11] body_count,
                                  // [34:24] post_count, [50:35] peak_level,
                                  // [55:51] zero
  output logic [4:0]  out_tuser,  // [1:0] role, [2] hit_start, [4:3] send_kind
  // Configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

`include "ae_hit_detector_macros.svh"

  ae_hd_pkg::cfg_t    cfg_r;
  ae_hd_pkg::stage_t  stage;
  ae_hd_pkg::result_t res;
  ae_hd_pkg::result_t res_r;
  logic               out_valid_r;
  logic               out_free;
  logic               step;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr <= ae_hd_pkg::THR_W'(1000);
      cfg_r.pdt <= ae_hd_pkg::TIME_W'(200);
      cfg_r.hdt <= ae_hd_pkg::TIME_W'(400);
      cfg_r.hlt <= ae_hd_pkg::TIME_W'(1000);
      cfg_r.mdt <= ae_hd_pkg::TIME_W'(4096);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ae_hd_pkg::REG_THR: cfg_r.thr <= cfg_wdata[ae_hd_pkg::THR_W-1:0];
        ae_hd_pkg::REG_PDT: cfg_r.pdt <= cfg_wdata;
        ae_hd_pkg::REG_HDT: cfg_r.hdt <= cfg_wdata;
        ae_hd_pkg::REG_HLT: cfg_r.hlt <= cfg_wdata;
        ae_hd_pkg::REG_MDT: cfg_r.mdt <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result register frees when empty or taken this cycle
  assign out_free = !out_valid_r || out_tready;
  assign step     = stage.valid && out_free;

  ae_hd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sample    (in_tdata),
    .thr       (cfg_r.thr),
    .take      (step),
    .stage     (stage)
  );

  ae_hd_track #(
    .PRE_DEPTH  (PRE_DEPTH),
    .BODY_DEPTH (BODY_DEPTH),
    .POST_DEPTH (POST_DEPTH)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .stage (stage),
    .step  (step),
    .res   (res)
  );

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {res_r.send_kind, res_r.hit_start, res_r.role};
  assign out_tdata  = {5'd0, res_r.peak_level, res_r.post_count,
                       res_r.body_count, res_r.pre_count};

  // Checks
  `AE_ASSERT_NOW(a_trunc_no_post,
    out_valid_r && res_r.send_kind == ae_hd_pkg::SEND_TRUNC,
    res_r.post_count == '0, "truncated send reports post samples")
  `AE_ASSERT_NOW(a_start_has_peak,
    out_valid_r && res_r.hit_start,
    res_r.peak_level != '0, "hit start without a peak level")
  `AE_ASSERT_NOW(a_pre_is_idle,
    out_valid_r && res_r.role == ae_hd_pkg::ROLE_PRE,
    res_r.peak_level == '0 && res_r.send_kind == ae_hd_pkg::SEND_NONE,
    "pre-trigger sample while a hit is open")
  `AE_ASSERT_NEXT(a_step_fills_out, step, out_valid_r,
    "sample left the input stage without reaching the result register")

endmodule
